[rtl/v3norm_pkg.sv]
// Shared constants for the three-component vector normalizer.
`default_nettype none

package v3norm_pkg;

    localparam int IN_WIDTH_DEF  = 18;
    localparam int FRAC_BITS_DEF = 14;

endpackage

`default_nettype wire

[rtl/v3norm_front.sv]
// Front pipeline: component magnitudes, squares, sum of squares and root seeds.
`default_nettype none

module v3norm_front
    import v3norm_pkg::*;
#(
    parameter int IN_WIDTH  = IN_WIDTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int SW = 2 * IN_WIDTH,
    localparam int W  = 2 * IN_WIDTH + 2 * FRAC_BITS + 6
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output      logic                          in_ready,
    input  wire logic [2:0][IN_WIDTH-1:0]      in_comp,
    output      logic                          out_valid,
    input  wire logic                          out_ready,
    output      logic [2:0]                    out_neg,
    output      logic                          out_zero,
    output      logic [SW-1:0]                 out_s,
    output      logic [2:0][W-1:0]             out_rem,
    output      logic [2:0][W-1:0]             out_p
);

    logic                     va_reg, vb_reg, vc_reg;
    logic                     rdy_a, rdy_b, rdy_c;
    logic [2:0][IN_WIDTH-1:0] mag_reg, mag_next;
    logic [2:0]               nega_reg, negb_reg, negc_reg;
    logic [2:0][SW-1:0]       sq_reg;
    logic [SW-1:0]            s_next, s_reg;
    logic [2:0][W-1:0]        rem_reg, rem_next;
    logic [W-1:0]             p_reg, p_next;
    logic                     zero_reg;

    assign rdy_c    = !vc_reg || out_ready;
    assign rdy_b    = !vb_reg || rdy_c;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i] = in_comp[i][IN_WIDTH-1] ? (~in_comp[i] + 1'b1) : in_comp[i];
        end
    end

    always_comb
    begin
        s_next = sq_reg[0] + sq_reg[1] + sq_reg[2];
        p_next = ~W'(s_next) + 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            rem_next[i] = (W'(sq_reg[i]) << (2 * FRAC_BITS + 2)) - W'(s_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a) va_reg <= in_valid;
            if (rdy_b) vb_reg <= va_reg;
            if (rdy_c) vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a)
        begin
            mag_reg <= mag_next;
            for (int i = 0; i < 3; i++)
            begin
                nega_reg[i] <= in_comp[i][IN_WIDTH-1];
            end
        end
        if (rdy_b)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= SW'(mag_reg[i]) * SW'(mag_reg[i]);
            end
            negb_reg <= nega_reg;
        end
        if (rdy_c)
        begin
            s_reg    <= s_next;
            rem_reg  <= rem_next;
            p_reg    <= p_next;
            zero_reg <= (s_next == '0);
            negc_reg <= negb_reg;
        end
    end

    assign out_valid = vc_reg;
    assign out_neg   = negc_reg;
    assign out_zero  = zero_reg;
    assign out_s     = s_reg;
    assign out_rem   = rem_reg;
    assign out_p     = {p_reg, p_reg, p_reg};

endmodule

`default_nettype wire

[rtl/v3norm_root_stage.sv]
// One result bit of the rounded scaled-magnitude search for all three lanes.
`default_nettype none

module v3norm_root_stage
    import v3norm_pkg::*;
#(
    parameter int IN_WIDTH  = IN_WIDTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int BIT       = FRAC_BITS_DEF,
    localparam int SW = 2 * IN_WIDTH,
    localparam int W  = 2 * IN_WIDTH + 2 * FRAC_BITS + 6,
    localparam int Q  = FRAC_BITS + 1
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output      logic                  in_ready,
    input  wire logic [2:0]            in_neg,
    input  wire logic                  in_zero,
    input  wire logic [SW-1:0]         in_s,
    input  wire logic [2:0][W-1:0]     in_rem,
    input  wire logic [2:0][W-1:0]     in_p,
    input  wire logic [2:0][Q-1:0]     in_q,
    output      logic                  out_valid,
    input  wire logic                  out_ready,
    output      logic [2:0]            out_neg,
    output      logic                  out_zero,
    output      logic [SW-1:0]         out_s,
    output      logic [2:0][W-1:0]     out_rem,
    output      logic [2:0][W-1:0]     out_p,
    output      logic [2:0][Q-1:0]     out_q
);

    localparam logic [Q-1:0] ONE     = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [Q-1:0] BIT_SEL = {{(Q-1){1'b0}}, 1'b1} << BIT;

    logic                  valid_reg;
    logic [2:0]            neg_reg;
    logic                  zero_reg;
    logic [SW-1:0]         s_reg;
    logic [2:0][W-1:0]     rem_reg, rem_next;
    logic [2:0][W-1:0]     p_reg, p_next;
    logic [2:0][Q-1:0]     q_reg, q_next;
    logic [W-1:0]          s_ext;
    logic [2:0][W-1:0]     trial;
    logic [2:0][Q-1:0]     cand;

    assign in_ready = !valid_reg || out_ready;
    assign s_ext    = W'(in_s);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cand[i]  = in_q[i] | BIT_SEL;
            trial[i] = in_rem[i] - (in_p[i] << (BIT + 2)) - (s_ext << (2 * BIT + 2));
            if ((cand[i] <= ONE) && !trial[i][W-1])
            begin
                rem_next[i] = trial[i];
                p_next[i]   = in_p[i] + (s_ext << (BIT + 1));
                q_next[i]   = cand[i];
            end
            else
            begin
                rem_next[i] = in_rem[i];
                p_next[i]   = in_p[i];
                q_next[i]   = in_q[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            neg_reg  <= in_neg;
            zero_reg <= in_zero;
            s_reg    <= in_s;
            rem_reg  <= rem_next;
            p_reg    <= p_next;
            q_reg    <= q_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_neg   = neg_reg;
    assign out_zero  = zero_reg;
    assign out_s     = s_reg;
    assign out_rem   = rem_reg;
    assign out_p     = p_reg;
    assign out_q     = q_reg;

endmodule

`default_nettype wire

[rtl/v3norm_out.sv]
// Output register: zero-vector default, clamp and sign restore.
`default_nettype none

module v3norm_out
    import v3norm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int Q  = FRAC_BITS + 1,
    localparam int OW = FRAC_BITS + 2
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output      logic                  in_ready,
    input  wire logic [2:0]            in_neg,
    input  wire logic                  in_zero,
    input  wire logic [2:0][Q-1:0]     in_q,
    output      logic                  out_valid,
    input  wire logic                  out_ready,
    output      logic [2:0][OW-1:0]    out_unit,
    output      logic                  out_zero
);

    localparam logic [Q-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic               valid_reg;
    logic [2:0][OW-1:0] unit_reg, unit_next;
    logic               zero_reg;
    logic [Q-1:0]       mag;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        mag = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag = (in_q[i] > ONE) ? ONE : in_q[i];
            if (in_neg[i] && (mag != '0))
            begin
                unit_next[i] = ~OW'(mag) + 1'b1;
            end
            else
            begin
                unit_next[i] = OW'(mag);
            end
        end
        if (in_zero)
        begin
            unit_next[0] = '0;
            unit_next[1] = '0;
            unit_next[2] = OW'(ONE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            unit_reg <= unit_next;
            zero_reg <= in_zero;
        end
    end

    assign out_valid = valid_reg;
    assign out_unit  = unit_reg;
    assign out_zero  = zero_reg;

endmodule

`default_nettype wire

[rtl/vector3_normalizer_unit.sv]
// Top level of the three-component vector normalizer.
//
//  channel  dir  tdata (low bit up)              tuser
//  s_axis   in   comp_x, comp_y, comp_z, pad     -
//  m_axis   out  unit_x, unit_y, unit_z          zero_input
//
//  One word per cycle sustained while m_axis_tready stays high; three front
//  stages, one digit stage per result bit, one output register.
//  The digit stages each resolve one bit of all three scaled magnitudes.
//  Reset clears only the valid bits of every stage.
//  Each stage holds while the next one is full and stalled; bubbles collapse.
`default_nettype none

module vector3_normalizer_unit
    import v3norm_pkg::*;
#(
    parameter int IN_WIDTH  = IN_WIDTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int SW  = 2 * IN_WIDTH,
    localparam int W   = 2 * IN_WIDTH + 2 * FRAC_BITS + 6,
    localparam int Q   = FRAC_BITS + 1,
    localparam int OW  = FRAC_BITS + 2,
    localparam int IDW = ((3 * IN_WIDTH + 7) / 8) * 8,
    localparam int ODW = ((3 * OW + 7) / 8) * 8,
    localparam int NS  = FRAC_BITS + 1
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_axis_tvalid,
    output      logic           s_axis_tready,
    input  wire logic [IDW-1:0] s_axis_tdata,   // comp_x, comp_y, comp_z, zero pad
    output      logic           m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output      logic [ODW-1:0] m_axis_tdata,   // unit_x, unit_y, unit_z, zero pad
    output      logic           m_axis_tuser    // zero_input
);

    logic [2:0][IN_WIDTH-1:0] comp;
    logic                     valid_c [0:NS];
    logic                     ready_c [0:NS];
    logic [2:0]               neg_c   [0:NS];
    logic                     zero_c  [0:NS];
    logic [SW-1:0]            s_c     [0:NS];
    logic [2:0][W-1:0]        rem_c   [0:NS];
    logic [2:0][W-1:0]        p_c     [0:NS];
    logic [2:0][Q-1:0]        q_c     [0:NS];
    logic [2:0][OW-1:0]       unit;

    assign comp = s_axis_tdata[3*IN_WIDTH-1:0];
    assign q_c[0] = '0;

    v3norm_front #(
        .IN_WIDTH  (IN_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_comp   (comp),
        .out_valid (valid_c[0]),
        .out_ready (ready_c[0]),
        .out_neg   (neg_c[0]),
        .out_zero  (zero_c[0]),
        .out_s     (s_c[0]),
        .out_rem   (rem_c[0]),
        .out_p     (p_c[0])
    );

    for (genvar k = 0; k < NS; k++)
    begin : g_digit
        v3norm_root_stage #(
            .IN_WIDTH  (IN_WIDTH),
            .FRAC_BITS (FRAC_BITS),
            .BIT       (FRAC_BITS - k)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_c[k]),
            .in_ready  (ready_c[k]),
            .in_neg    (neg_c[k]),
            .in_zero   (zero_c[k]),
            .in_s      (s_c[k]),
            .in_rem    (rem_c[k]),
            .in_p      (p_c[k]),
            .in_q      (q_c[k]),
            .out_valid (valid_c[k+1]),
            .out_ready (ready_c[k+1]),
            .out_neg   (neg_c[k+1]),
            .out_zero  (zero_c[k+1]),
            .out_s     (s_c[k+1]),
            .out_rem   (rem_c[k+1]),
            .out_p     (p_c[k+1]),
            .out_q     (q_c[k+1])
        );
    end

    v3norm_out #(
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_c[NS]),
        .in_ready  (ready_c[NS]),
        .in_neg    (neg_c[NS]),
        .in_zero   (zero_c[NS]),
        .in_q      (q_c[NS]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_unit  (unit),
        .out_zero  (m_axis_tuser)
    );

    assign m_axis_tdata = ODW'(unit);

    localparam logic [OW-1:0] ONE_OUT  = {2'b01, {FRAC_BITS{1'b0}}};
    localparam logic [OW-1:0] MONE_OUT = {2'b11, {FRAC_BITS{1'b0}}};

    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while output path is free");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
        (unit[0] == '0 && unit[1] == '0 && unit[2] == ONE_OUT))
    else $error("zero vector did not give the default direction");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
        (($signed(unit[0]) <= $signed(ONE_OUT)) && ($signed(unit[0]) >= $signed(MONE_OUT)) &&
         ($signed(unit[1]) <= $signed(ONE_OUT)) && ($signed(unit[1]) >= $signed(MONE_OUT)) &&
         ($signed(unit[2]) <= $signed(ONE_OUT)) && ($signed(unit[2]) >= $signed(MONE_OUT))))
    else $error("normalized component outside unit range");

endmodule

`default_nettype wire

[dv/vector3_normalizer_unit_tb.sv]
// Testbench for the vector normalizer: queued stimulus, clocked driver and monitor, scoreboard.
`default_nettype none

module vector3_normalizer_unit_tb;
    import v3norm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IW  = IN_WIDTH_DEF;
    localparam int FB  = FRAC_BITS_DEF;
    localparam int OW  = FB + 2;
    localparam int IDW = ((3 * IW + 7) / 8) * 8;
    localparam int ODW = ((3 * OW + 7) / 8) * 8;
    localparam int LIMIT = 2000000;

    typedef struct packed {
        logic signed [IW-1:0] z;
        logic signed [IW-1:0] y;
        logic signed [IW-1:0] x;
    } vec_in_t;

    typedef struct {
        logic [OW-1:0] ux;
        logic [OW-1:0] uy;
        logic [OW-1:0] uz;
        logic          zflag;
    } unit_vec_t;

    logic           clk;
    logic           rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [IDW-1:0] s_axis_tdata;
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [ODW-1:0] m_axis_tdata;
    logic           m_axis_tuser;

    vec_in_t   pending_vecs[$];
    unit_vec_t expected_units[$];
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_off;
    int        errors;
    int        cycles;

    vector3_normalizer_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [63:0] magnitude(input logic signed [IW-1:0] c);
        logic signed [63:0] w;
        begin
            w = c;
            return (w < 0) ? -w : w;
        end
    endfunction

    // largest q <= 2^FB with (2q-1)^2 * s <= 4 * m^2 * 2^(2FB)
    function automatic logic [63:0] rounded_quotient(input logic [63:0] m, input logic [63:0] s);
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [63:0]  q;
        logic [63:0]  t;
        begin
            rhs = (128'(m * m)) << (2 * FB + 2);
            q = 0;
            for (int b = FB; b >= 0; b--)
            begin
                t = q | (64'd1 << b);
                if (t <= (64'd1 << FB))
                begin
                    lhs = 128'((2 * t - 1) * (2 * t - 1)) * 128'(s);
                    if (lhs <= rhs)
                        q = t;
                end
            end
            return q;
        end
    endfunction

    function automatic unit_vec_t normalize(input vec_in_t v);
        unit_vec_t     r;
        logic [63:0]   mg[3];
        logic          ng[3];
        logic [63:0]   s;
        logic [63:0]   one;
        logic [63:0]   q;
        logic [OW-1:0] o[3];
        begin
            mg[0] = magnitude(v.x);
            mg[1] = magnitude(v.y);
            mg[2] = magnitude(v.z);
            ng[0] = v.x[IW-1];
            ng[1] = v.y[IW-1];
            ng[2] = v.z[IW-1];
            one = 64'd1 << FB;
            s = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
            if (s == 0)
            begin
                r.ux = '0;
                r.uy = '0;
                r.uz = OW'(one);
                r.zflag = 1'b1;
                return r;
            end
            for (int i = 0; i < 3; i++)
            begin
                if (s == one * one)
                    q = (mg[i] > one) ? one : mg[i];
                else
                    q = rounded_quotient(mg[i], s);
                o[i] = (ng[i] && q != 0) ? OW'(-q) : OW'(q);
            end
            r.ux = o[0];
            r.uy = o[1];
            r.uz = o[2];
            r.zflag = 1'b0;
            return r;
        end
    endfunction

    function automatic logic signed [IW-1:0] rand_comp();
        int k;
        begin
            k = $urandom_range(0, 9);
            if (k == 0)
                return $urandom_range(0, 1) ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
            if (k < 3)
                return IW'($signed($urandom_range(0, 64)) - 32);
            if (k < 5)
                return IW'($signed($urandom_range(0, 32768)) - 16384);
            return IW'($urandom);
        end
    endfunction

    task automatic add_vec(input int x, input int y, input int z);
        vec_in_t v;
        begin
            v.x = IW'(x);
            v.y = IW'(y);
            v.z = IW'(z);
            pending_vecs.push_back(v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_vecs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                vec_in_t v;
                v = pending_vecs.pop_front();
                expected_units.push_back(normalize(v));
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= IDW'(v);
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_off > 0)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    always @(posedge clk)
    begin
        unit_vec_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_units.size() == 0)
            begin
                $error("unexpected word: tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
                errors++;
            end
            else
            begin
                e = expected_units.pop_front();
                if (m_axis_tdata[OW-1:0] !== e.ux)
                begin
                    $error("unit_x expected %h got %h", e.ux, m_axis_tdata[OW-1:0]);
                    errors++;
                end
                if (m_axis_tdata[2*OW-1:OW] !== e.uy)
                begin
                    $error("unit_y expected %h got %h", e.uy, m_axis_tdata[2*OW-1:OW]);
                    errors++;
                end
                if (m_axis_tdata[3*OW-1:2*OW] !== e.uz)
                begin
                    $error("unit_z expected %h got %h", e.uz, m_axis_tdata[3*OW-1:2*OW]);
                    errors++;
                end
                if (m_axis_tuser !== e.zflag)
                begin
                    $error("zero_input expected %b got %b", e.zflag, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic run_phase(input int idle, input int stall, input int count);
        begin
            send_idle_pct = idle;
            recv_stall_pct = stall;
            for (int i = 0; i < count; i++)
                add_vec(rand_comp(), rand_comp(), rand_comp());
            while (pending_vecs.size() != 0)
                @(posedge clk);
        end
    endtask

    initial
    begin
        int one;
        one = 1 << FB;
        errors = 0;
        cycles = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        add_vec(0, 0, 0);
        add_vec(one, 0, 0);
        add_vec(0, -one, 0);
        add_vec(0, 0, one);
        add_vec(8192, 8192, 11585);
        add_vec(-131072, -131072, -131072);
        add_vec(131071, 131071, 131071);
        add_vec(-131072, 0, 0);
        add_vec(131071, -131072, 1);
        add_vec(1, 0, 0);
        add_vec(-1, 1, -1);
        add_vec(3, 4, 0);
        add_vec(-3, 0, 4);
        add_vec(1, 1, 1);
        add_vec(0, 1, 0);
        add_vec(one, one, one);
        add_vec(2 * one, 0, 0);
        add_vec(-one / 2, -one / 2, 0);
        add_vec(12, 5, 0);
        add_vec(0, 0, -1);
        run_phase(0, 0, 0);

        run_phase(0, 0, 350);
        run_phase(69, 0, 350);
        run_phase(0, 69, 350);
        run_phase(14, 14, 350);

        hold_off = 300;
        run_phase(0, 0, 130);

        while (expected_units.size() != 0)
            @(posedge clk);
        repeat (FB + 30) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/v3norm_pkg.sv
rtl/v3norm_front.sv
rtl/v3norm_root_stage.sv
rtl/v3norm_out.sv
rtl/vector3_normalizer_unit.sv
dv/vector3_normalizer_unit_tb.sv
